@@ design/stc_pkg.sv @@
`timescale 1ns / 1ps

package stc_pkg;

    // Number of simple types the table can hold; type 0 (object) is implicit.
    localparam int MAX_TYPES = 64;

    // Width of a type id on the channels.
    localparam int ID_W = 7;

    // Width of the type counter, which must be able to hold MAX_TYPES itself.
    localparam int CNT_W = $clog2(MAX_TYPES + 1);

    // Row address of the relation matrix.
    localparam int ROW_AW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;

    // Common width for comparing ids against the counter.
    localparam int CMP_W = (ID_W > CNT_W) ? ID_W : CNT_W;

    typedef logic [ID_W-1:0]      id_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CMP_W-1:0]     cmp_t;
    typedef logic [ROW_AW-1:0]    raddr_t;
    typedef logic [MAX_TYPES-1:0] row_t;

    typedef enum logic [1:0] {
        REQ_ADD_TYPE  = 2'd0,
        REQ_ADD_SUPER = 2'd1,
        REQ_QUERY     = 2'd2,
        REQ_UNUSED    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_CYCLE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BAD_ID = 2'd3
    } status_t;

    // Result of testing one matrix row against the pending update.
    typedef struct packed {
        logic bit_a;   // row holds the column of type a
        logic bit_b;   // row holds the column of type b
        logic hit;     // row is at or below a and not yet at or below b
    } row_eval_t;

endpackage

@@ design/stc_in_if.sv @@
`timescale 1ns / 1ps

interface stc_in_if;
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    stc_pkg::id_t     type_a;
    stc_pkg::id_t     type_b;

    modport source (output valid, output req_type, output type_a, output type_b,
                    input ready);
    modport sink   (input valid, input req_type, input type_a, input type_b,
                    output ready);
endinterface

@@ design/stc_out_if.sv @@
`timescale 1ns / 1ps

interface stc_out_if;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    stc_pkg::id_t     new_type_id;
    logic             is_subtype;

    modport source (output valid, output status, output new_type_id,
                    output is_subtype, input ready);
    modport sink   (input valid, input status, input new_type_id,
                    input is_subtype, output ready);
endinterface

@@ design/stc_ram.sv @@
`timescale 1ns / 1ps

module stc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/stc_row_unit.sv @@
`timescale 1ns / 1ps

// Shared row test and merge: used for the lookups of rows a and b and for
// every step of the closure sweep.
module stc_row_unit (
    input  stc_pkg::row_t      row,
    input  stc_pkg::raddr_t    a_idx,
    input  stc_pkg::raddr_t    b_idx,
    input  stc_pkg::raddr_t    k_idx,
    input  stc_pkg::row_t      add_row,
    output stc_pkg::row_eval_t eval,
    output stc_pkg::row_t      merged
);

    always_comb
    begin
        eval.bit_a = row[a_idx];
        eval.bit_b = row[b_idx];
        eval.hit   = ((k_idx == a_idx) || row[a_idx]) &&
                     !((k_idx == b_idx) || row[b_idx]);
        merged     = row | add_row;
    end

endmodule

@@ design/subtype_closure_table.sv @@
`timescale 1ns / 1ps

// Channel  Modport  Payload                              Transfer when
// -------  -------  -----------------------------------  ----------------------
// in_ch    sink     req_type, type_a, type_b             in_ch.valid & ready
// out_ch   source   status, new_type_id, is_subtype      out_ch.valid & ready
//
// One request is worked on at a time; in_ch.ready is high only while idle.
// Add-type, bad ids and requests decided from the ids alone go straight from
// idle to finish; a query that needs the matrix or an add-supertype already
// implied by row a also reads row a, one rejected as a cycle by row b reads
// row b too, and an add-supertype that changes the closure then sweeps all
// type_count rows through the single matrix read port, one row per cycle.
// Reset is asynchronous and active low; the matrix needs no clearing pass
// because a row is written to zero when its type is created.
// A stalled result holds the block in its finish state until out_ch drains.
module subtype_closure_table (
    input  logic      clk,
    input  logic      rst_n,
    stc_in_if.sink    in_ch,
    stc_out_if.source out_ch
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_SWEEP,
        S_FINISH
    } state_t;

    state_t               state_reg;
    stc_pkg::cnt_t        type_count_reg;
    stc_pkg::raddr_t      a_idx_reg;
    stc_pkg::raddr_t      b_idx_reg;
    stc_pkg::raddr_t      k_idx_reg;
    stc_pkg::row_t        add_reg;
    logic                 is_query_reg;
    stc_pkg::status_t     res_status_reg;
    stc_pkg::id_t         res_new_id_reg;
    logic                 res_sub_reg;
    logic                 out_valid_reg;
    stc_pkg::status_t     out_status_reg;
    stc_pkg::id_t         out_new_id_reg;
    logic                 out_sub_reg;

    // Matrix port signals.
    logic                 ram_we;
    stc_pkg::raddr_t      ram_waddr;
    stc_pkg::row_t        ram_wdata;
    stc_pkg::raddr_t      ram_raddr;
    stc_pkg::row_t        ram_rdata;

    stc_pkg::row_eval_t   eval;
    stc_pkg::row_t        merged;

    stc_pkg::req_t        in_req;
    logic                 in_accept;
    logic                 table_full;
    logic                 ids_bad;
    logic                 sweep_last;
    logic                 out_load;

    // Outcome of a request as far as it can be decided from the ids alone.
    stc_pkg::status_t     dec_status;
    stc_pkg::id_t         dec_new_id;
    logic                 dec_sub;
    state_t               dec_state;

    assign in_req     = stc_pkg::req_t'(in_ch.req_type);
    assign in_accept  = in_ch.valid && in_ch.ready;
    assign table_full = (type_count_reg == stc_pkg::cnt_t'(stc_pkg::MAX_TYPES));
    assign ids_bad    = (stc_pkg::cmp_t'(in_ch.type_a) > stc_pkg::cmp_t'(type_count_reg)) ||
                        (stc_pkg::cmp_t'(in_ch.type_b) > stc_pkg::cmp_t'(type_count_reg));
    assign sweep_last = (stc_pkg::cmp_t'(k_idx_reg) + stc_pkg::cmp_t'(1)) ==
                        stc_pkg::cmp_t'(type_count_reg);

    // The finished result moves to the output register once it is free or
    // being transferred in this same cycle.
    assign out_load   = (state_reg == S_FINISH) && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.new_type_id = out_new_id_reg;
    assign out_ch.is_subtype  = out_sub_reg;

    // The matrix: row i-1 holds the strict supertypes of type i.
    stc_ram #(
        .WIDTH (stc_pkg::MAX_TYPES),
        .DEPTH (stc_pkg::MAX_TYPES)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stc_row_unit u_row_unit (
        .row     (ram_rdata),
        .a_idx   (a_idx_reg),
        .b_idx   (b_idx_reg),
        .k_idx   (k_idx_reg),
        .add_row (add_reg),
        .eval    (eval),
        .merged  (merged)
    );

    // Matrix port control. Reads are registered, so each state issues the read
    // whose data the following state consumes. During the sweep, row k is
    // written back while row k+1 is being read.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = k_idx_reg;
        ram_wdata = merged;
        ram_raddr = k_idx_reg + stc_pkg::raddr_t'(1);
        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = stc_pkg::raddr_t'(in_ch.type_a - stc_pkg::id_t'(1));
                // A new type starts with an empty row.
                if (in_accept && (in_req == stc_pkg::REQ_ADD_TYPE) && !table_full)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = stc_pkg::raddr_t'(type_count_reg);
                    ram_wdata = '0;
                end
            end
            S_RD_A:
            begin
                ram_raddr = b_idx_reg;
            end
            S_RD_B:
            begin
                ram_raddr = '0;
            end
            S_SWEEP:
            begin
                ram_we = eval.hit;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Requests that the ids settle go straight to the finish state; the rest
    // go on to read row a.
    always_comb
    begin
        dec_status = stc_pkg::ST_OK;
        dec_new_id = '0;
        dec_sub    = 1'b0;
        dec_state  = S_FINISH;
        case (in_req)
            stc_pkg::REQ_ADD_TYPE:
            begin
                if (table_full)
                begin
                    dec_status = stc_pkg::ST_FULL;
                end
                else
                begin
                    dec_new_id = stc_pkg::id_t'(type_count_reg + stc_pkg::cnt_t'(1));
                end
            end
            stc_pkg::REQ_ADD_SUPER, stc_pkg::REQ_QUERY:
            begin
                if (ids_bad)
                begin
                    dec_status = stc_pkg::ST_BAD_ID;
                end
                else if (in_ch.type_a == in_ch.type_b)
                begin
                    // Identity is always a subtype.
                    dec_sub = (in_req == stc_pkg::REQ_QUERY);
                end
                else if (in_ch.type_a == '0)
                begin
                    // Object is below nothing; making it so is a cycle.
                    if (in_req == stc_pkg::REQ_ADD_SUPER)
                    begin
                        dec_status = stc_pkg::ST_CYCLE;
                    end
                end
                else if (in_ch.type_b == '0)
                begin
                    // Everything is below object.
                    dec_sub = (in_req == stc_pkg::REQ_QUERY);
                end
                else
                begin
                    dec_state = S_RD_A;
                end
            end
            default:
            begin
                dec_status = stc_pkg::ST_BAD_ID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            type_count_reg <= '0;
            a_idx_reg      <= '0;
            b_idx_reg      <= '0;
            k_idx_reg      <= '0;
            add_reg        <= '0;
            is_query_reg   <= 1'b0;
            res_status_reg <= stc_pkg::ST_OK;
            res_new_id_reg <= '0;
            res_sub_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= stc_pkg::ST_OK;
            out_new_id_reg <= '0;
            out_sub_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        a_idx_reg      <= stc_pkg::raddr_t'(in_ch.type_a - stc_pkg::id_t'(1));
                        b_idx_reg      <= stc_pkg::raddr_t'(in_ch.type_b - stc_pkg::id_t'(1));
                        is_query_reg   <= (in_req == stc_pkg::REQ_QUERY);
                        res_status_reg <= dec_status;
                        res_new_id_reg <= dec_new_id;
                        res_sub_reg    <= dec_sub;
                        state_reg      <= dec_state;
                        if ((in_req == stc_pkg::REQ_ADD_TYPE) && !table_full)
                        begin
                            type_count_reg <= type_count_reg + stc_pkg::cnt_t'(1);
                        end
                    end
                end

                S_RD_A:
                begin
                    // Row a is on the read port: is a already below b?
                    if (is_query_reg)
                    begin
                        res_sub_reg <= eval.bit_b;
                        state_reg   <= S_FINISH;
                    end
                    else if (eval.bit_b)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_RD_B;
                    end
                end

                S_RD_B:
                begin
                    // Row b is on the read port: would the new edge close a cycle?
                    if (eval.bit_a)
                    begin
                        res_status_reg <= stc_pkg::ST_CYCLE;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        add_reg   <= ram_rdata | (stc_pkg::row_t'(1) << b_idx_reg);
                        k_idx_reg <= '0;
                        state_reg <= S_SWEEP;
                    end
                end

                S_SWEEP:
                begin
                    if (sweep_last)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        k_idx_reg <= k_idx_reg + stc_pkg::raddr_t'(1);
                    end
                end

                S_FINISH:
                begin
                    if (out_load)
                    begin
                        out_status_reg <= res_status_reg;
                        out_new_id_reg <= res_new_id_reg;
                        out_sub_reg    <= res_sub_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The sweep only ever rewrites rows of types that exist.
    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SWEEP) && ram_we) |->
            (stc_pkg::cmp_t'(k_idx_reg) < stc_pkg::cmp_t'(type_count_reg)))
        else $error("sweep wrote a row beyond the type count");

    // A full report is only given when the table really is full.
    a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == stc_pkg::ST_FULL)) |->
            (type_count_reg == stc_pkg::cnt_t'(stc_pkg::MAX_TYPES)))
        else $error("table full reported below capacity");

    // A new id or a positive answer only comes with an ok status.
    a_fields_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_new_id_reg != '0) || out_sub_reg)) |->
            (out_status_reg == stc_pkg::ST_OK))
        else $error("result fields set on a failed request");
`endif

endmodule

@@ test/subtype_closure_table_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the subtype closure table. Requests are queued up
// front, driven on the falling edge by a driver process, and every transfer
// into the block is run through a local model of the closed relation to
// produce the result that must come back. The monitor on the result channel
// compares each returned transfer with the oldest outstanding expectation.
module subtype_closure_table_test;

    // Generous bound: about 850 requests, each with its busy time and the idle
    // gaps on either side, taken several times over.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 750;
    localparam int MAX_PRINTED  = 50;

    typedef struct {
        stc_pkg::req_t req;
        stc_pkg::id_t  type_a;
        stc_pkg::id_t  type_b;
        bit            drain;    // hold this request back until every result is in
    } stc_req_t;

    typedef struct {
        stc_pkg::status_t status;
        stc_pkg::id_t     new_id;
        logic             sub;
    } stc_res_t;

    logic clk;
    logic rst_n;

    stc_in_if  in_ch ();
    stc_out_if out_ch ();

    subtype_closure_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    stc_req_t pending_reqs[$];
    stc_res_t expected_results[$];

    // Local copy of the relation. Bit j-1 of row i-1 is set when type i is
    // strictly below type j; object and the diagonal are implied.
    int            known_types;
    stc_pkg::row_t below_rows [stc_pkg::MAX_TYPES];

    // Count of add-type requests queued so far, capped at MAX_TYPES, used while building stimulus.
    int gen_types;

    int  mismatches;
    int  cycles;
    int  closure_updates;
    int  status_seen [4];
    int  query_hits;
    bit  in_fire;
    bit  out_fire;
    int  send_wait;
    int  recv_wait;
    bit  send_burst;
    bit  recv_burst;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function bit is_under(input int a, input int b);
        if (a == b)
            return 1'b1;
        if (a == 0)
            return 1'b0;
        if (b == 0)
            return 1'b1;
        return below_rows[a-1][b-1];
    endfunction

    // Applies one request to the local relation and returns the result the
    // block has to produce for it.
    function stc_res_t predict_result(input stc_req_t r);
        stc_res_t      res;
        int            a;
        int            b;
        stc_pkg::row_t add_cols;
        res.status = stc_pkg::ST_OK;
        res.new_id = '0;
        res.sub    = 1'b0;
        a = r.type_a;
        b = r.type_b;
        if (r.req == stc_pkg::REQ_ADD_TYPE)
        begin
            if (known_types >= stc_pkg::MAX_TYPES)
                res.status = stc_pkg::ST_FULL;
            else
            begin
                known_types++;
                res.new_id = stc_pkg::id_t'(known_types);
            end
        end
        else if (r.req == stc_pkg::REQ_UNUSED || a > known_types || b > known_types)
            res.status = stc_pkg::ST_BAD_ID;
        else if (r.req == stc_pkg::REQ_QUERY)
            res.sub = is_under(a, b);
        else if (is_under(a, b))
            res.status = stc_pkg::ST_OK;
        else if (is_under(b, a))
            res.status = stc_pkg::ST_CYCLE;
        else
        begin
            // Everything at or below a that is not yet below b picks up b
            // together with all of b's supertypes.
            add_cols = below_rows[b-1];
            add_cols[b-1] = 1'b1;
            for (int k = 1; k <= known_types; k++)
            begin
                if (is_under(k, a) && !is_under(k, b))
                    below_rows[k-1] |= add_cols;
            end
            closure_updates++;
        end
        return res;
    endfunction

    function int draw_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 15));
    endfunction

    task push_req(input stc_pkg::req_t req, input int a, input int b, input bit drain);
        stc_req_t r;
        r.req    = req;
        r.type_a = stc_pkg::id_t'(a);
        r.type_b = stc_pkg::id_t'(b);
        r.drain  = drain;
        pending_reqs.insert(pending_reqs.size(), r);
        if (req == stc_pkg::REQ_ADD_TYPE && gen_types < stc_pkg::MAX_TYPES)
            gen_types++;
    endtask

    task report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Draws one request with ids mostly inside the defined range, so that
    // most add-supertype requests really reach the closure update.
    task push_random_req(input bit drain);
        int            pick;
        int            a;
        int            b;
        stc_pkg::req_t req;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            req = stc_pkg::REQ_ADD_TYPE;
        else if (pick < 52)
            req = stc_pkg::REQ_ADD_SUPER;
        else if (pick < 95)
            req = stc_pkg::REQ_QUERY;
        else
            req = stc_pkg::REQ_UNUSED;
        a = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127)
                                         : $urandom_range(0, gen_types);
        b = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127)
                                         : $urandom_range(0, gen_types);
        push_req(req, a, b, drain);
    endtask

    // Stimulus, reset and the end of the run.
    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.req_type  = stc_pkg::REQ_ADD_TYPE;
        in_ch.type_a    = '0;
        in_ch.type_b    = '0;
        out_ch.ready    = 1'b0;
        known_types     = 0;
        gen_types       = 0;
        mismatches      = 0;
        cycles          = 0;
        closure_updates = 0;
        query_hits      = 0;
        in_fire         = 1'b0;
        out_fire        = 1'b0;
        send_wait       = 0;
        recv_wait       = 0;
        send_burst      = 1'b0;
        recv_burst      = 1'b0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        for (int i = 0; i < stc_pkg::MAX_TYPES; i++)
            below_rows[i] = '0;

        // Directed part: empty table, unused code, object on either side,
        // implied relations, cycles and out-of-range ids.
        push_req(stc_pkg::REQ_QUERY, 0, 0, 1'b0);
        push_req(stc_pkg::REQ_QUERY, 1, 0, 1'b0);
        push_req(stc_pkg::REQ_UNUSED, 127, 127, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 0, 0, 1'b0);
        for (int i = 0; i < 4; i++)
            push_req(stc_pkg::REQ_ADD_TYPE, 0, 0, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 1, 2, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 2, 3, 1'b0);
        push_req(stc_pkg::REQ_QUERY, 1, 3, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 3, 1, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 0, 2, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 4, 0, 1'b0);
        push_req(stc_pkg::REQ_QUERY, 0, 4, 1'b0);
        push_req(stc_pkg::REQ_QUERY, 4, 0, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 1, 3, 1'b0);
        push_req(stc_pkg::REQ_QUERY, 3, 1, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 5, 1, 1'b0);
        push_req(stc_pkg::REQ_QUERY, 1, 127, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 4, 1, 1'b0);
        push_req(stc_pkg::REQ_QUERY, 4, 3, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 3, 4, 1'b0);
        push_req(stc_pkg::REQ_UNUSED, 0, 0, 1'b0);

        // Random part; every so often the sender lets the block drain fully.
        for (int i = 0; i < RANDOM_ITEMS; i++)
            push_random_req(i % 150 == 0);

        // Fill the table, then run into the full case and the top id.
        while (gen_types < stc_pkg::MAX_TYPES)
            push_req(stc_pkg::REQ_ADD_TYPE, 0, 0, 1'b0);
        push_req(stc_pkg::REQ_ADD_TYPE, 0, 0, 1'b1);
        push_req(stc_pkg::REQ_ADD_TYPE, 0, 0, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, stc_pkg::MAX_TYPES, 1, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, stc_pkg::MAX_TYPES - 1, stc_pkg::MAX_TYPES, 1'b0);
        push_req(stc_pkg::REQ_QUERY, stc_pkg::MAX_TYPES - 1, 1, 1'b0);
        push_req(stc_pkg::REQ_QUERY, stc_pkg::MAX_TYPES, stc_pkg::MAX_TYPES, 1'b0);
        push_req(stc_pkg::REQ_ADD_SUPER, 1, stc_pkg::MAX_TYPES, 1'b0);
        push_req(stc_pkg::REQ_QUERY, stc_pkg::MAX_TYPES + 1, 0, 1'b0);
        for (int i = 0; i < 40; i++)
            push_random_req(1'b0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests ending with %0d types: %0d closure updates, %0d cycles",
                 status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
                 known_types, closure_updates, status_seen[stc_pkg::ST_CYCLE]);
        $display("rejected, %0d full-table answers, %0d bad ids, %0d query hits.",
                 status_seen[stc_pkg::ST_FULL], status_seen[stc_pkg::ST_BAD_ID], query_hits);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Request driver. A new request goes out only once the previous one has
    // been transferred and its idle gap has run out.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_fire)
            begin
                if (send_wait > 0)
                begin
                    in_ch.valid <= 1'b0;
                    send_wait--;
                end
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && expected_results.size() != 0))
                begin
                    in_ch.valid    <= 1'b1;
                    in_ch.req_type <= pending_reqs[0].req;
                    in_ch.type_a   <= pending_reqs[0].type_a;
                    in_ch.type_b   <= pending_reqs[0].type_b;
                    void'(pending_reqs.pop_front());
                    if ($urandom_range(0, 39) == 0)
                        send_burst = !send_burst;
                    send_wait = draw_wait(send_burst);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver. After every transfer it draws an idle gap, zero in burst
    // mode, so that back-pressure holds the block in its finish state.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                recv_wait = draw_wait(recv_burst);
            end
            if (recv_wait > 0)
            begin
                out_ch.ready <= 1'b0;
                recv_wait--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Sampling at the rising edge: request transfers feed the model, result
    // transfers are checked against it.
    always @(posedge clk)
    begin
        stc_res_t want;
        stc_res_t exp_res;
        stc_req_t got_req;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end

        in_fire  = rst_n && in_ch.valid && in_ch.ready;
        out_fire = rst_n && out_ch.valid && out_ch.ready;

        if (in_fire)
        begin
            got_req.req    = stc_pkg::req_t'(in_ch.req_type);
            got_req.type_a = in_ch.type_a;
            got_req.type_b = in_ch.type_b;
            got_req.drain  = 1'b0;
            exp_res = predict_result(got_req);
            expected_results.insert(expected_results.size(), exp_res);
        end

        if (out_fire)
        begin
            status_seen[out_ch.status]++;
            if (out_ch.is_subtype === 1'b1)
                query_hits++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result transfer with none outstanding (status %0d)",
                                          out_ch.status));
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              out_ch.status, want.status.name()));
                if (out_ch.new_type_id !== want.new_id)
                    report_mismatch($sformatf("new_type_id %0d, expected %0d",
                                              out_ch.new_type_id, want.new_id));
                if (out_ch.is_subtype !== want.sub)
                    report_mismatch($sformatf("is_subtype %b, expected %b",
                                              out_ch.is_subtype, want.sub));
            end
        end
    end

endmodule
